>>> design/rhf_pkg.sv
// Shared types, constants and arithmetic helpers for the ripple height field engine.
package rhf_pkg;

    localparam int GRID_SIDE = 64;
    localparam int MAP_SIDE  = GRID_SIDE + 2;
    localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W    = $clog2(MAP_CELLS);
    localparam int COORD_W   = $clog2(MAP_SIDE);
    localparam int ROW_W     = 7;
    localparam int CMP_W     = ((ROW_W > COORD_W) ? ROW_W : COORD_W) + 1;
    localparam int HEIGHT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 4;
    localparam int CHAIN_LEN = 5;

    localparam logic [1:0] REQ_DISTURB = 2'd0;
    localparam logic [1:0] REQ_STEP    = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSES  = 2'd1;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [ROW_W-1:0]           cell_row;
        logic [ROW_W-1:0]           cell_col;
        logic signed [HEIGHT_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] read_height;
        logic                       done_res;
    } res_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIST,
        ST_UPD,
        ST_ROWB,
        ST_COLB,
        ST_SMOOTH,
        ST_READ,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        SRC_H0,
        SRC_H1,
        SRC_SM
    } src_t;

    typedef logic [COORD_W-1:0] wrap_lut_t [2**ROW_W];

    function automatic wrap_lut_t build_wrap();
        wrap_lut_t lut;
        for (int i = 0; i < 2**ROW_W; i++) begin
            if (i > GRID_SIDE) begin
                lut[i] = COORD_W'(((i - 1) % GRID_SIDE) + 1);
            end else begin
                lut[i] = COORD_W'(i);
            end
        end
        return lut;
    endfunction

    localparam wrap_lut_t WRAP_LUT = build_wrap();

    function automatic logic [ADDR_W-1:0] cell_addr(logic [COORD_W-1:0] r,
                                                    logic [COORD_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAP_SIDE) + ADDR_W'(c);
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] sat20(logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'sh7fff;
        end else if (v < -20'sd32768) begin
            return 16'sh8000;
        end
        return v[HEIGHT_W-1:0];
    endfunction

endpackage

>>> design/ripple_height_field_engine_top.sv
// Top level of the ripple height field engine: sequencer, height maps and operand chain.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_data   (rhf_pkg::req_t)
//  m_      | out       | m_valid / m_ready  | m_data   (rhf_pkg::res_t)
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Disturb and in-range read finish after a map read; type three goes straight to finish.
// A step updates each interior cell from its four neighbours and old value, fills the
// border rows and columns, then runs the configured smoothing passes, paced by the single
// read port of each map feeding the operand chain one value a cycle. After reset a clearing
// pass zeroes all 4356 cells of each map; no item is taken meanwhile.
// A finished result waits in the output register while the next item is taken.
module ripple_height_field_engine_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rhf_pkg::req_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rhf_pkg::res_t                     m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rhf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rhf_pkg::CFG_W-1:0]         cfg_data
);
    localparam int AW = rhf_pkg::ADDR_W;
    localparam int CW = rhf_pkg::COORD_W;
    localparam int HW = rhf_pkg::HEIGHT_W;
    localparam int NC = rhf_pkg::CHAIN_LEN;

    rhf_pkg::state_t          state_reg, state_next;
    logic [2:0]               phase_reg, phase_next;
    logic [CW-1:0]            row_reg, row_next;
    logic [CW-1:0]            col_reg, col_next;
    logic [3:0]               pass_reg, pass_next;
    logic [AW-1:0]            clr_reg, clr_next;
    logic                     bs_reg, bs_next;
    logic [3:0]               damp_reg, damp_next;
    logic [3:0]               passes_reg, passes_next;
    rhf_pkg::req_t            req_reg, req_next;
    rhf_pkg::res_t            res_reg, res_next;
    logic                     m_valid_reg, m_valid_next;
    rhf_pkg::res_t            m_data_reg, m_data_next;
    logic                     rd_pend_reg, rd_pend_next;
    rhf_pkg::src_t            rd_src_reg, rd_src_next;

    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic signed [HW-1:0]     wr_data;
    logic                     we_h0, we_h1, we_sm;
    logic [HW-1:0]            rd_h0, rd_h1, rd_sm;
    logic signed [HW-1:0]     chain_in;
    logic signed [HW-1:0]     chain_q [NC];

    rhf_pkg::src_t            src_cur, src_old;
    logic signed [17:0]       nb_sum;
    logic signed [18:0]       upd_v;
    logic signed [19:0]       upd_d;
    logic signed [18:0]       sm_sum;
    logic signed [19:0]       dist_v;
    logic                     in_range;

    rhf_ram #(.WIDTH(HW), .DEPTH(rhf_pkg::MAP_CELLS)) u_map0 (
        .aclk(aclk), .wr_en(we_h0), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_h0)
    );
    rhf_ram #(.WIDTH(HW), .DEPTH(rhf_pkg::MAP_CELLS)) u_map1 (
        .aclk(aclk), .wr_en(we_h1), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_h1)
    );
    rhf_ram #(.WIDTH(HW), .DEPTH(rhf_pkg::MAP_CELLS)) u_smooth (
        .aclk(aclk), .wr_en(we_sm), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_sm)
    );

    always_comb begin
        case (rd_src_reg)
            rhf_pkg::SRC_H0: chain_in = rd_h0;
            rhf_pkg::SRC_H1: chain_in = rd_h1;
            default:         chain_in = rd_sm;
        endcase
    end

    for (genvar i = 0; i < NC; i++) begin : g_chain
        if (i == 0) begin : g_head
            rhf_cell u_cell (.aclk(aclk), .shift_en(rd_pend_reg), .d_in(chain_in),
                             .q_out(chain_q[i]));
        end else begin : g_body
            rhf_cell u_cell (.aclk(aclk), .shift_en(rd_pend_reg), .d_in(chain_q[i-1]),
                             .q_out(chain_q[i]));
        end
    end

    assign src_cur = bs_reg ? rhf_pkg::SRC_H1 : rhf_pkg::SRC_H0;
    assign src_old = bs_reg ? rhf_pkg::SRC_H0 : rhf_pkg::SRC_H1;

    assign nb_sum = 18'(chain_q[1]) + 18'(chain_q[2]) + 18'(chain_q[3]) + 18'(chain_q[4]);
    assign upd_v  = 19'(nb_sum >>> 1) - 19'(chain_q[0]);
    assign upd_d  = 20'(upd_v) - 20'(upd_v >>> damp_reg);
    assign sm_sum = (19'(chain_q[3]) <<< 1) + 19'(chain_q[3]) + (19'(chain_q[2]) <<< 1)
                  + (19'(chain_q[1]) <<< 1) + 19'(chain_q[0]);
    assign dist_v = 20'(chain_q[0]) - 20'(req_reg.amount);
    assign in_range = (rhf_pkg::CMP_W'(s_data.cell_row) <= rhf_pkg::CMP_W'(rhf_pkg::MAP_SIDE - 1))
                   && (rhf_pkg::CMP_W'(s_data.cell_col) <= rhf_pkg::CMP_W'(rhf_pkg::MAP_SIDE - 1));

    assign s_ready   = (state_reg == rhf_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rhf_pkg::ST_CLEAR;
            phase_reg   <= '0;
            clr_reg     <= '0;
            bs_reg      <= 1'b0;
            damp_reg    <= 4'd4;
            passes_reg  <= 4'd4;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            clr_reg     <= clr_next;
            bs_reg      <= bs_next;
            damp_reg    <= damp_next;
            passes_reg  <= passes_next;
            m_valid_reg <= m_valid_next;
            rd_pend_reg <= rd_pend_next;
        end
        row_reg    <= row_next;
        col_reg    <= col_next;
        pass_reg   <= pass_next;
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        rd_src_reg <= rd_src_next;
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        pass_next    = pass_reg;
        clr_next     = clr_reg;
        bs_next      = bs_reg;
        damp_next    = damp_reg;
        passes_next  = passes_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rd_pend_next = 1'b0;
        rd_src_next  = rd_src_reg;
        rd_addr      = rhf_pkg::cell_addr(row_reg, col_reg);
        wr_addr      = rhf_pkg::cell_addr(row_reg, col_reg);
        wr_data      = chain_q[0];
        we_h0        = 1'b0;
        we_h1        = 1'b0;
        we_sm        = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index)
                rhf_pkg::CFG_DAMPING: damp_next   = cfg_data;
                rhf_pkg::CFG_PASSES:  passes_next = cfg_data;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rhf_pkg::ST_CLEAR: begin
                wr_addr  = clr_reg;
                wr_data  = '0;
                we_h0    = 1'b1;
                we_h1    = 1'b1;
                we_sm    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(rhf_pkg::MAP_CELLS - 1)) begin
                    state_next = rhf_pkg::ST_IDLE;
                end
            end
            rhf_pkg::ST_IDLE: begin
                phase_next = '0;
                if (s_valid) begin
                    req_next          = s_data;
                    res_next.read_height = '0;
                    res_next.done_res = 1'b1;
                    unique case (s_data.req_type)
                        rhf_pkg::REQ_DISTURB: begin
                            row_next   = rhf_pkg::WRAP_LUT[s_data.cell_row];
                            col_next   = rhf_pkg::WRAP_LUT[s_data.cell_col];
                            state_next = rhf_pkg::ST_DIST;
                        end
                        rhf_pkg::REQ_STEP: begin
                            row_next   = CW'(1);
                            col_next   = CW'(1);
                            state_next = rhf_pkg::ST_UPD;
                        end
                        rhf_pkg::REQ_READ: begin
                            row_next   = CW'(s_data.cell_row);
                            col_next   = CW'(s_data.cell_col);
                            state_next = in_range ? rhf_pkg::ST_READ : rhf_pkg::ST_FINISH;
                        end
                        default: begin
                            res_next.done_res = 1'b0;
                            state_next        = rhf_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            rhf_pkg::ST_DIST: begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 3'd0) begin
                    rd_pend_next = 1'b1;
                    rd_src_next  = src_old;
                end else if (phase_reg == 3'd2) begin
                    wr_data    = rhf_pkg::sat20(dist_v);
                    we_h0      = bs_reg;
                    we_h1      = !bs_reg;
                    state_next = rhf_pkg::ST_FINISH;
                end
            end
            rhf_pkg::ST_READ: begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 3'd0) begin
                    rd_pend_next = 1'b1;
                    rd_src_next  = rhf_pkg::SRC_SM;
                end else if (phase_reg == 3'd2) begin
                    res_next.read_height = chain_q[0];
                    state_next           = rhf_pkg::ST_FINISH;
                end
            end
            rhf_pkg::ST_UPD: begin
                phase_next = phase_reg + 1'b1;
                case (phase_reg)
                    3'd0: rd_addr = rhf_pkg::cell_addr(CW'(row_reg - 1'b1), col_reg);
                    3'd1: rd_addr = rhf_pkg::cell_addr(CW'(row_reg + 1'b1), col_reg);
                    3'd2: rd_addr = rhf_pkg::cell_addr(row_reg, CW'(col_reg - 1'b1));
                    3'd3: rd_addr = rhf_pkg::cell_addr(row_reg, CW'(col_reg + 1'b1));
                    default: rd_addr = rhf_pkg::cell_addr(row_reg, col_reg);
                endcase
                if (phase_reg <= 3'd4) begin
                    rd_pend_next = 1'b1;
                    rd_src_next  = (phase_reg == 3'd4) ? src_old : src_cur;
                end
                if (phase_reg == 3'd6) begin
                    wr_data    = rhf_pkg::sat20(upd_d);
                    we_h0      = bs_reg;
                    we_h1      = !bs_reg;
                    phase_next = '0;
                    if (col_reg == CW'(rhf_pkg::GRID_SIDE)) begin
                        col_next = CW'(1);
                        row_next = CW'(row_reg + 1'b1);
                        if (row_reg == CW'(rhf_pkg::GRID_SIDE)) begin
                            col_next   = '0;
                            state_next = rhf_pkg::ST_ROWB;
                        end
                    end else begin
                        col_next = CW'(col_reg + 1'b1);
                    end
                end
            end
            rhf_pkg::ST_ROWB: begin
                phase_next = phase_reg + 1'b1;
                rd_addr    = rhf_pkg::cell_addr(CW'(1), col_reg);
                if (phase_reg == 3'd0) begin
                    rd_pend_next = 1'b1;
                    rd_src_next  = src_old;
                end else if (phase_reg == 3'd2) begin
                    wr_addr = rhf_pkg::cell_addr('0, col_reg);
                    we_h0   = bs_reg;
                    we_h1   = !bs_reg;
                end else if (phase_reg == 3'd3) begin
                    wr_addr    = rhf_pkg::cell_addr(CW'(rhf_pkg::MAP_SIDE - 1), col_reg);
                    we_h0      = bs_reg;
                    we_h1      = !bs_reg;
                    phase_next = '0;
                    col_next   = CW'(col_reg + 1'b1);
                    if (col_reg == CW'(rhf_pkg::MAP_SIDE - 1)) begin
                        row_next   = '0;
                        state_next = rhf_pkg::ST_COLB;
                    end
                end
            end
            rhf_pkg::ST_COLB: begin
                phase_next = phase_reg + 1'b1;
                rd_addr    = rhf_pkg::cell_addr(row_reg, CW'(1));
                if (phase_reg == 3'd0) begin
                    rd_pend_next = 1'b1;
                    rd_src_next  = src_old;
                end else if (phase_reg == 3'd2) begin
                    wr_addr = rhf_pkg::cell_addr(row_reg, '0);
                    we_h0   = bs_reg;
                    we_h1   = !bs_reg;
                end else if (phase_reg == 3'd3) begin
                    wr_addr    = rhf_pkg::cell_addr(row_reg, CW'(rhf_pkg::MAP_SIDE - 1));
                    we_h0      = bs_reg;
                    we_h1      = !bs_reg;
                    phase_next = '0;
                    row_next   = CW'(row_reg + 1'b1);
                    if (row_reg == CW'(rhf_pkg::GRID_SIDE)) begin
                        bs_next   = !bs_reg;
                        row_next  = CW'(1);
                        col_next  = CW'(1);
                        pass_next = 4'd1;
                        state_next = (passes_reg == 4'd0) ? rhf_pkg::ST_FINISH
                                                          : rhf_pkg::ST_SMOOTH;
                    end
                end
            end
            rhf_pkg::ST_SMOOTH: begin
                phase_next = phase_reg + 1'b1;
                case (phase_reg)
                    3'd0: rd_addr = rhf_pkg::cell_addr(row_reg, col_reg);
                    3'd1: rd_addr = rhf_pkg::cell_addr(CW'(row_reg + 1'b1), col_reg);
                    3'd2: rd_addr = rhf_pkg::cell_addr(row_reg, CW'(col_reg + 1'b1));
                    default: rd_addr = rhf_pkg::cell_addr(CW'(row_reg + 1'b1),
                                                          CW'(col_reg + 1'b1));
                endcase
                if (phase_reg <= 3'd3) begin
                    rd_pend_next = 1'b1;
                    rd_src_next  = (pass_reg == 4'd1) ? src_old : rhf_pkg::SRC_SM;
                end
                if (phase_reg == 3'd5) begin
                    wr_data    = sm_sum[18:3];
                    we_sm      = 1'b1;
                    phase_next = '0;
                    if (col_reg == CW'(rhf_pkg::GRID_SIDE)) begin
                        col_next = CW'(1);
                        row_next = CW'(row_reg + 1'b1);
                        if (row_reg == CW'(rhf_pkg::GRID_SIDE)) begin
                            row_next  = CW'(1);
                            pass_next = pass_reg + 1'b1;
                            if (pass_reg == passes_reg) begin
                                state_next = rhf_pkg::ST_FINISH;
                            end
                        end
                    end else begin
                        col_next = CW'(col_reg + 1'b1);
                    end
                end
            end
            rhf_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = rhf_pkg::ST_IDLE;
                end
            end
            default: state_next = rhf_pkg::ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_one_map_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != rhf_pkg::ST_CLEAR) |-> !(we_h0 && we_h1))
        else $error("both height maps written outside clearing");
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == rhf_pkg::ST_FINISH))
        else $error("result raised outside finish");
    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= 3'd6)
        else $error("phase counter overran");
    a_swap_only_at_step_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (bs_reg != $past(bs_reg)) |-> $past(state_reg == rhf_pkg::ST_COLB))
        else $error("map swap outside border pass");
`endif
endmodule

>>> design/rhf_ram.sv
// Generic single write port RAM with registered read.
module rhf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

>>> design/rhf_cell.sv
// One operand cell of the stencil chain: takes its neighbour's value on each shift.
module rhf_cell (
    input  logic                                aclk,
    input  logic                                shift_en,
    input  logic signed [rhf_pkg::HEIGHT_W-1:0] d_in,
    output logic signed [rhf_pkg::HEIGHT_W-1:0] q_out
);
    logic signed [rhf_pkg::HEIGHT_W-1:0] val_reg;
    logic signed [rhf_pkg::HEIGHT_W-1:0] val_next;

    always_comb begin
        val_next = shift_en ? d_in : val_reg;
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign q_out = val_reg;
endmodule
